// File: rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and codes for the ordered list table.
// ----------------------------------------------------------------------------
package olt_pkg;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_POS   = 3'd1,
        OP_INS_BACK  = 3'd2,
        OP_SEARCH    = 3'd3,
        OP_DELETE    = 3'd4,
        OP_LIST      = 3'd5
    } olt_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_LIST
    } olt_state_t;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    localparam int VAL_W = 32;
    localparam int POS_W = 16;

endpackage

// File: rtl/ordered_list_table_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_table_unit
// Bounded ordered list of signed 32-bit values held in a single RAM.
// ----------------------------------------------------------------------------
// Input: an operation is transferred when start is high and busy is low.
// busy stays high until the operation's last result has been produced.
// Results: each result is shown for one cycle with result_valid high; the
// receiver takes every result and cannot stall the block.
// Operation flow (one RAM read and one RAM write per cycle):
//   unknown operation, full insert, empty delete/list: result set in the
//     dispatch state, then registered.
//   insert at index k: entries from k up move up one a cycle, then the value is written at k.
//   search: a scan from the front to the first match or the end; delete: the same scan,
//     then the tail moves down one a cycle.
//   list out: elements in order from index 0, one per cycle.
// A new operation can be transferred in the cycle its predecessor's last
// result is shown. The RAM walk sets the rate: one entry per cycle.
// Reset empties the list and drops any operation in progress; RAM contents
// are left as they are and no value read from them is used before being written.
// ----------------------------------------------------------------------------
module ordered_list_table_unit
    import olt_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              operation,
    input  logic signed [VAL_W-1:0] item_value,
    input  logic signed [POS_W-1:0] position,
    output logic                    result_valid,
    output logic [1:0]              status,
    output logic                    found,
    output logic signed [VAL_W-1:0] element,
    output logic                    last,
    output logic [CNT_W-1:0]        length
);

    olt_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   pend_addr_reg, pend_addr_next;

    olt_op_t            op_reg;
    logic [2:0]         op_raw_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [POS_W-1:0]   pos_reg;

    logic               res_valid_reg, res_valid_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               res_found_reg, res_found_next;
    logic [VAL_W-1:0]   res_element_reg, res_element_next;
    logic               res_last_reg, res_last_next;
    logic [CNT_W-1:0]   res_length_reg, res_length_next;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [VAL_W-1:0]   ram_wr_data;
    logic [AW-1:0]      ram_rd_addr;
    logic [VAL_W-1:0]   ram_rd_data;

    logic               accept;
    logic               full;
    logic               hit;
    logic               op_known;
    logic [CNT_W-1:0]   ptr_dec;
    logic [CNT_W-1:0]   ptr_inc;
    logic [CNT_W-1:0]   pa_dec;
    logic [CNT_W-1:0]   pa_inc;
    logic [CNT_W-1:0]   count_dec;
    logic [CNT_W-1:0]   count_inc;
    logic [CNT_W-1:0]   ins_idx;

    olt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign hit       = pend_reg && (ram_rd_data == val_reg);
    assign op_known  = (op_raw_reg <= 3'(OP_LIST));
    assign ptr_dec   = ptr_reg - 1'b1;
    assign ptr_inc   = ptr_reg + 1'b1;
    assign pa_dec    = pend_addr_reg - 1'b1;
    assign pa_inc    = pend_addr_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        ins_idx = '0;
        if (op_reg == OP_INS_BACK)
        begin
            ins_idx = count_reg;
        end
        else if (op_reg == OP_INS_POS && !pos_reg[POS_W-1])
        begin
            if (pos_reg[POS_W-2:0] >= (POS_W-1)'(count_reg))
            begin
                ins_idx = count_reg;
            end
            else
            begin
                ins_idx = pos_reg[CNT_W-1:0];
            end
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_raw_reg <= operation;
            op_reg     <= olt_op_t'(operation);
            val_reg    <= item_value;
            pos_reg    <= position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        pend_addr_reg   <= pend_addr_next;
        res_status_reg  <= res_status_next;
        res_found_reg   <= res_found_next;
        res_element_reg <= res_element_next;
        res_last_reg    <= res_last_next;
        res_length_reg  <= res_length_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        idx_next         = idx_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        res_valid_next   = 1'b0;
        res_status_next  = STAT_OK;
        res_found_next   = 1'b0;
        res_element_next = '0;
        res_last_next    = 1'b1;
        res_length_next  = count_reg;
        ram_rd_addr      = ptr_reg[AW-1:0];
        ram_wr_en        = 1'b0;
        ram_wr_addr      = '0;
        ram_wr_data      = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                ptr_next  = '0;
                pend_next = 1'b0;
                if (!op_known)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    unique case (op_reg) inside
                        OP_INS_FRONT, OP_INS_POS, OP_INS_BACK:
                        begin
                            if (full)
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = STAT_FULL;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                idx_next   = ins_idx;
                                ptr_next   = count_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_SEARCH:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_DELETE, OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = STAT_EMPTY;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                state_next = (op_reg == OP_LIST) ? S_LIST : S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    pend_next = 1'b0;
                    if (op_reg == OP_SEARCH)
                    begin
                        res_valid_next = 1'b1;
                        res_found_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = pa_inc;
                        state_next = S_SHIFT_DN;
                    end
                end
                else if (ptr_reg < count_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg;
                    ptr_next       = ptr_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = (op_reg == OP_SEARCH) ? STAT_OK : STAT_NOT_FOUND;
                        state_next      = S_IDLE;
                    end
                end
            end

            S_SHIFT_DN:
            begin
                if (pend_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = pa_dec[AW-1:0];
                    ram_wr_data = ram_rd_data;
                end
                if (ptr_reg < count_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg;
                    ptr_next       = ptr_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next      = count_dec;
                        res_valid_next  = 1'b1;
                        res_length_next = count_dec;
                        state_next      = S_IDLE;
                    end
                end
            end

            S_SHIFT_UP:
            begin
                ram_rd_addr = ptr_dec[AW-1:0];
                if (pend_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = pa_inc[AW-1:0];
                    ram_wr_data = ram_rd_data;
                end
                if (ptr_reg > idx_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_dec;
                    ptr_next       = ptr_dec;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = idx_reg[AW-1:0];
                        ram_wr_data     = val_reg;
                        count_next      = count_inc;
                        res_valid_next  = 1'b1;
                        res_length_next = count_inc;
                        state_next      = S_IDLE;
                    end
                end
            end

            S_LIST:
            begin
                if (pend_reg)
                begin
                    res_valid_next   = 1'b1;
                    res_element_next = ram_rd_data;
                    res_last_next    = (pend_addr_reg == count_dec);
                end
                if (ptr_reg < count_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg;
                    ptr_next       = ptr_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (pend_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign found        = res_found_reg;
    assign element      = res_element_reg;
    assign last         = res_last_reg;
    assign length       = res_length_reg;

endmodule

// File: rtl/olt_ram.sv
// ----------------------------------------------------------------------------
// olt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module olt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/olt_check.sv
// ----------------------------------------------------------------------------
// olt_check
// Port-level checks for the ordered list table, bound to the top level.
// ----------------------------------------------------------------------------
module olt_check
    import olt_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int CNT_W = $clog2(CAPACITY + 1)
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    result_valid,
    input logic [1:0]              status,
    input logic                    found,
    input logic signed [VAL_W-1:0] element,
    input logic                    last,
    input logic [CNT_W-1:0]        length
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transfer accepted but block not busy");

    a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("intermediate result while idle");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && found |-> status == STAT_OK && last && element == '0)
        else $error("found flag with bad status or element");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == STAT_FULL |-> length == CNT_W'(CAPACITY))
        else $error("full status with list not full");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == STAT_EMPTY |-> length == '0 && last)
        else $error("empty status with nonzero length");

endmodule

bind ordered_list_table_unit olt_check #(
    .CAPACITY (CAPACITY)
) u_olt_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .found        (found),
    .element      (element),
    .last         (last),
    .length       (length)
);
